// ===== rtl/multiset_bag_table_defines.svh =====
// Assertion macros for the multiset bag table.
`ifndef MULTISET_BAG_TABLE_DEFINES_SVH
`define MULTISET_BAG_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// check on every clock edge out of reset
`define MBAG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mbag check failed");
// check that also runs while reset is held
`define MBAG_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mbag reset check failed");
`else
`define MBAG_ASSERT(lbl, prop)
`define MBAG_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/mbag_pkg.sv =====
// Shared types and constants for the multiset bag table.
`default_nettype none
package mbag_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_COUNT  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] match_count;
    logic [COUNT_W-1:0] entry_count;
    logic               is_full;
    logic               is_empty;
  } out_beat_t;

endpackage
`default_nettype wire

// ===== rtl/mbag_store.sv =====
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module mbag_store #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32,
  parameter int AW         = 4
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [ITEM_WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]         rd_addr,
  output      logic [ITEM_WIDTH-1:0] rd_data
);

  logic [ITEM_WIDTH-1:0] mem [CAPACITY];
  logic [ITEM_WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/mbag_ctrl.sv =====
// Sequencer: walks the entry memory through one comparator per operation.
`default_nettype none
module mbag_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire mbag_pkg::in_beat_t              in_data,
  output      logic                            busy,
  input  wire logic                            cfg_we,
  input  wire logic [mbag_pkg::LIMIT_W-1:0]    cfg_data,
  input  wire logic                            res_ready,
  output      logic                            res_valid,
  output      mbag_pkg::out_beat_t             res_data,
  output      logic [AW-1:0]                   rd_addr,
  input  wire logic [ITEM_WIDTH-1:0]           rd_data,
  output      logic                            wr_en,
  output      logic [AW-1:0]                   wr_addr,
  output      logic [ITEM_WIDTH-1:0]           wr_data
);

  // width wide enough for both the limit register and the held count
  localparam int LW = (CW > mbag_pkg::LIMIT_W) ? CW : mbag_pkg::LIMIT_W;

  mbag_pkg::state_t              state_r, state_nxt;
  mbag_pkg::op_t                 op_r, op_nxt;
  mbag_pkg::status_t             status_r, status_nxt;
  logic [ITEM_WIDTH-1:0]         val_r, val_nxt;
  logic [CW-1:0]                 n_r, n_nxt;
  logic [CW-1:0]                 rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]                 match_r, match_nxt;
  logic                          cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]                 cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]                 hit_idx_r, hit_idx_nxt;
  logic [mbag_pkg::LIMIT_W-1:0]  cap_r;

  logic [LW-1:0]                 eff_lim;
  logic [CW-1:0]                 n_m1;
  logic                          hit;
  logic                          last;
  logic                          issue;
  logic                          full_now;
  logic [ITEM_WIDTH-1:0]         in_val;

  // limit register; saturated to the memory depth where it is used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= mbag_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  assign eff_lim = (LW'(cap_r) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(cap_r);

  // shared compare against the value under search
  assign n_m1     = n_r - CW'(1);
  assign hit      = cmp_vld_r && (rd_data == val_r);
  assign last     = cmp_vld_r && (cmp_idx_r == n_m1[AW-1:0]);
  assign issue    = rd_idx_r < n_r;
  assign full_now = LW'(n_r) >= eff_lim;
  assign in_val   = ITEM_WIDTH'(in_data.item_value);

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mbag_pkg::S_IDLE;
      n_r       <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      n_r       <= n_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    val_r     <= val_nxt;
    rd_idx_r  <= rd_idx_nxt;
    match_r   <= match_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
  end

  // next state and memory port control
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    val_nxt     = val_r;
    n_nxt       = n_r;
    rd_idx_nxt  = rd_idx_r;
    match_nxt   = match_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    hit_idx_nxt = hit_idx_r;
    rd_addr     = rd_idx_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = n_r[AW-1:0];
    wr_data     = in_val;
    res_valid   = 1'b0;

    unique case (state_r)
      mbag_pkg::S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          op_nxt     = in_data.op;
          val_nxt    = in_val;
          match_nxt  = '0;
          status_nxt = mbag_pkg::ST_OK;
          state_nxt  = mbag_pkg::S_DONE;
          unique case (in_data.op)
            mbag_pkg::OP_ADD: begin
              if (full_now) begin
                status_nxt = mbag_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                n_nxt = n_r + CW'(1);
              end
            end
            mbag_pkg::OP_REMOVE, mbag_pkg::OP_COUNT: begin
              if (n_r == '0) begin
                status_nxt = mbag_pkg::ST_NOT_FOUND;
              end else begin
                // first read goes out now, its compare follows in the next cycle
                rd_idx_nxt  = CW'(1);
                cmp_vld_nxt = 1'b1;
                cmp_idx_nxt = '0;
                state_nxt   = mbag_pkg::S_SCAN;
              end
            end
            mbag_pkg::OP_CLEAR: begin
              n_nxt = '0;
            end
          endcase
        end
      end

      mbag_pkg::S_SCAN: begin
        if (issue) begin
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[AW-1:0];
        end
        if (op_r == mbag_pkg::OP_REMOVE) begin
          if (hit) begin
            // fetch the last entry to fill the hole
            rd_addr     = n_m1[AW-1:0];
            hit_idx_nxt = cmp_idx_r;
            cmp_vld_nxt = 1'b0;
            state_nxt   = mbag_pkg::S_MOVE;
          end else if (last) begin
            status_nxt = mbag_pkg::ST_NOT_FOUND;
            state_nxt  = mbag_pkg::S_DONE;
          end
        end else begin
          if (hit) begin
            match_nxt = match_r + CW'(1);
          end
          if (last) begin
            status_nxt = (match_nxt == '0) ? mbag_pkg::ST_NOT_FOUND : mbag_pkg::ST_OK;
            state_nxt  = mbag_pkg::S_DONE;
          end
        end
      end

      mbag_pkg::S_MOVE: begin
        wr_en      = 1'b1;
        wr_addr    = hit_idx_r;
        wr_data    = rd_data;
        n_nxt      = n_m1;
        status_nxt = mbag_pkg::ST_OK;
        state_nxt  = mbag_pkg::S_DONE;
      end

      mbag_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = mbag_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mbag_pkg::S_IDLE;
      end
    endcase
  end

  // result beat, counts truncated to the field width; match count only for count
  always_comb begin
    res_data.status      = status_r;
    res_data.match_count = (op_r == mbag_pkg::OP_COUNT) ?
                           mbag_pkg::COUNT_W'(match_r) : '0;
    res_data.entry_count = mbag_pkg::COUNT_W'(n_r);
    res_data.is_full     = full_now;
    res_data.is_empty    = (n_r == '0);
  end

  assign busy = (state_r != mbag_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/multiset_bag_table.sv =====
// Top level of the multiset bag table: sequencer, entry memory, result register.
//
//   channel  direction  handshake        beat
//   in_      in         valid / stall    op, item_value
//   out_     out        valid / stall    status, match_count, entry_count, flags
//   cfg_     in         valid / ready    capacity_limit
//
// Add and clear: no scan; the done state hands the result to the output register.
// Remove and count: a scan of the held entries in the single-read-port entry
// memory through one comparator; a remove that hits adds a move state.
// in_stall stays high from an accepted beat until its result moves to the
// output register; that register holds a valid result while out_stall is high.
// Reset (rst_n low, synchronous) empties the bag and sets the limit to 16.
`default_nettype none
`include "multiset_bag_table_defines.svh"
module multiset_bag_table #(
  parameter int CAPACITY   = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire mbag_pkg::in_beat_t           in_data,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      mbag_pkg::out_beat_t          out_data,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [mbag_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  busy;
  logic                  res_ready;
  logic                  res_valid;
  mbag_pkg::out_beat_t   res_data;
  logic [AW-1:0]         rd_addr;
  logic [ITEM_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ITEM_WIDTH-1:0] wr_data;
  logic                  out_valid_r, out_valid_nxt;
  mbag_pkg::out_beat_t   out_data_r;

  mbag_ctrl #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .busy      (busy),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  mbag_store #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH),
    .AW         (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  // checks
  `MBAG_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)
  `MBAG_ASSERT(a_full_flag, (out_valid && out_data.status == mbag_pkg::ST_FULL) |-> out_data.is_full)
  `MBAG_ASSERT(a_match_ok, (out_valid && out_data.match_count != '0) |-> (out_data.status == mbag_pkg::ST_OK))
  `MBAG_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_valid && !in_stall))

endmodule
`default_nettype wire

// ===== tb/sv/tb_multiset_bag_table.sv =====
// Self-checking testbench for multiset_bag_table: directed table, then randomized phases.
`default_nettype none
module tb_multiset_bag_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          BAG_DEPTH = 16;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_BEATS = 75;
  localparam int          NUM_PHASES = 12;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  mbag_pkg::in_beat_t            in_data;
  logic                          out_valid;
  logic                          out_stall;
  mbag_pkg::out_beat_t           out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [mbag_pkg::LIMIT_W-1:0]  cfg_data;

  multiset_bag_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the bag
  logic [31:0]                  bag_store [BAG_DEPTH];
  int unsigned                  bag_held = 0;
  logic [mbag_pkg::LIMIT_W-1:0] bag_limit = mbag_pkg::LIMIT_RST;

  // Results still owed by the block, oldest first
  mbag_pkg::out_beat_t pending_results [$];

  // Hand-typed result that travels with the beat on the input channel
  bit                  beat_has_want;
  mbag_pkg::out_beat_t beat_want;

  bit holdoff_req = 0;
  int errs = 0;
  int n_add = 0, n_remove = 0, n_count = 0, n_clear = 0;
  int n_rejected = 0, n_missed = 0, n_limits = 0;

  // Directed stimulus table
  typedef struct {
    bit                           is_cfg;
    logic [mbag_pkg::LIMIT_W-1:0] limit;
    mbag_pkg::op_t                op;
    logic [31:0]                  val;
    bit                           has_want;
    mbag_pkg::out_beat_t          want;
  } bag_row_t;

  bag_row_t directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic mbag_pkg::out_beat_t mk_result(mbag_pkg::status_t st, int mc, int ec,
                                                    bit f, bit e);
    mbag_pkg::out_beat_t r;
    r.status      = st;
    r.match_count = mc[mbag_pkg::COUNT_W-1:0];
    r.entry_count = ec[mbag_pkg::COUNT_W-1:0];
    r.is_full     = f;
    r.is_empty    = e;
    return r;
  endfunction

  // Apply one operation to the shadow bag and return the result it should give
  function automatic mbag_pkg::out_beat_t bag_apply(mbag_pkg::in_beat_t b);
    mbag_pkg::out_beat_t r;
    int unsigned         lim;
    int unsigned         hits;
    bit                  found;
    lim = (bag_limit > BAG_DEPTH) ? BAG_DEPTH : bag_limit;
    hits = 0;
    found = 0;
    r.status = mbag_pkg::ST_OK;
    case (b.op)
      mbag_pkg::OP_ADD: begin
        if (bag_held >= lim) begin
          r.status = mbag_pkg::ST_FULL;
        end else begin
          bag_store[bag_held] = b.item_value;
          bag_held++;
        end
      end
      mbag_pkg::OP_REMOVE: begin
        // first match takes the last entry, then the bag shrinks
        for (int i = 0; i < bag_held; i++) begin
          if (!found && bag_store[i] == b.item_value) begin
            bag_store[i] = bag_store[bag_held-1];
            found = 1;
          end
        end
        if (found) bag_held--;
        else r.status = mbag_pkg::ST_NOT_FOUND;
      end
      mbag_pkg::OP_COUNT: begin
        for (int i = 0; i < bag_held; i++)
          if (bag_store[i] == b.item_value) hits++;
        if (hits == 0) r.status = mbag_pkg::ST_NOT_FOUND;
      end
      default: begin
        bag_held = 0;
      end
    endcase
    r.match_count = hits[mbag_pkg::COUNT_W-1:0];
    r.entry_count = bag_held[mbag_pkg::COUNT_W-1:0];
    r.is_full     = (bag_held >= lim);
    r.is_empty    = (bag_held == 0);
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    errs++;
    $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Beat tracking on both channels
  always @(posedge clk) begin
    mbag_pkg::out_beat_t exp_r;
    mbag_pkg::out_beat_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing pending, entry_count", out_data.entry_count, 0);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data.status !== exp_r.status)
            flag_mismatch("status", out_data.status, exp_r.status);
          if (out_data.match_count !== exp_r.match_count)
            flag_mismatch("match_count", out_data.match_count, exp_r.match_count);
          if (out_data.entry_count !== exp_r.entry_count)
            flag_mismatch("entry_count", out_data.entry_count, exp_r.entry_count);
          if (out_data.is_full !== exp_r.is_full)
            flag_mismatch("is_full", out_data.is_full, exp_r.is_full);
          if (out_data.is_empty !== exp_r.is_empty)
            flag_mismatch("is_empty", out_data.is_empty, exp_r.is_empty);
        end
      end
      if (in_valid && !in_stall) begin
        pred = bag_apply(in_data);
        case (in_data.op)
          mbag_pkg::OP_ADD:    n_add++;
          mbag_pkg::OP_REMOVE: n_remove++;
          mbag_pkg::OP_COUNT:  n_count++;
          default:             n_clear++;
        endcase
        if (pred.status == mbag_pkg::ST_FULL) n_rejected++;
        if (pred.status == mbag_pkg::ST_NOT_FOUND) n_missed++;
        pending_results.insert(pending_results.size(), beat_has_want ? beat_want : pred);
      end
    end
  end

  // Receiver: random stall segments, plus one long hold-off on request
  initial begin
    int seg_left;
    int seg_mode;
    out_stall = 1'b0;
    seg_left = 0;
    seg_mode = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holdoff_req = 0;
        out_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        case (seg_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one beat and hold it until the block takes it
  task automatic drive_op(mbag_pkg::op_t op, logic [31:0] v, bit has_want,
                          mbag_pkg::out_beat_t want);
    in_valid      <= 1'b1;
    in_data       <= {op, v};
    beat_has_want <= has_want;
    beat_want     <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // One edge first so a beat taken in this time step is already queued
  task automatic wait_drained();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Limit writes happen only with the bag idle
  task automatic write_limit(logic [mbag_pkg::LIMIT_W-1:0] lim);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bag_limit = lim;
    n_limits++;
    cfg_valid <= 1'b0;
  endtask

  task automatic row_cfg(logic [mbag_pkg::LIMIT_W-1:0] lim);
    bag_row_t r;
    r.is_cfg = 1;
    r.limit = lim;
    r.op = mbag_pkg::OP_CLEAR;
    r.val = '0;
    r.has_want = 0;
    r.want = '0;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task automatic row_chk(mbag_pkg::op_t op, logic [31:0] v, mbag_pkg::status_t st, int mc,
                         int ec, bit f, bit e);
    bag_row_t r;
    r.is_cfg = 0;
    r.limit = '0;
    r.op = op;
    r.val = v;
    r.has_want = 1;
    r.want = mk_result(st, mc, ec, f, e);
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // row checked against the shadow bag
  task automatic row_op(mbag_pkg::op_t op, logic [31:0] v);
    bag_row_t r;
    r.is_cfg = 0;
    r.limit = '0;
    r.op = op;
    r.val = v;
    r.has_want = 0;
    r.want = '0;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  initial begin
    logic [31:0]                  pool [4];
    logic [mbag_pkg::LIMIT_W-1:0] limit_plan [9];
    logic [mbag_pkg::LIMIT_W-1:0] lim;
    mbag_pkg::op_t                op;
    logic [31:0]                  v;
    int                           left, burst, gap, r;
    int                           add_pct, rem_pct;

    limit_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd16, 5'd2, 5'd17, 5'd8, 5'd16};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    beat_has_want = 0;
    beat_want = '0;

    // empty bag, extremes of the value, count and remove hits and misses
    row_chk(mbag_pkg::OP_COUNT,  32'd5,    mbag_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
    row_chk(mbag_pkg::OP_REMOVE, 32'd5,    mbag_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
    row_chk(mbag_pkg::OP_ADD,    32'd0,    mbag_pkg::ST_OK,        0, 1, 0, 0);
    row_chk(mbag_pkg::OP_ADD,    ALL_ONES, mbag_pkg::ST_OK,        0, 2, 0, 0);
    row_op(mbag_pkg::OP_ADD,     32'd0);
    row_op(mbag_pkg::OP_COUNT,   32'd0);
    row_chk(mbag_pkg::OP_COUNT,  ALL_ONES, mbag_pkg::ST_OK,        1, 3, 0, 0);
    row_op(mbag_pkg::OP_REMOVE,  32'd0);
    row_chk(mbag_pkg::OP_REMOVE, 32'd7,    mbag_pkg::ST_NOT_FOUND, 0, 2, 0, 0);
    row_chk(mbag_pkg::OP_CLEAR,  ALL_ONES, mbag_pkg::ST_OK,        0, 0, 0, 1);
    // limit of one; removing the only entry
    row_cfg(5'd1);
    row_chk(mbag_pkg::OP_ADD,    32'd3,    mbag_pkg::ST_OK,        0, 1, 1, 0);
    row_chk(mbag_pkg::OP_ADD,    32'd3,    mbag_pkg::ST_FULL,      0, 1, 1, 0);
    row_chk(mbag_pkg::OP_REMOVE, 32'd3,    mbag_pkg::ST_OK,        0, 0, 0, 1);
    // zero limit: full at once
    row_cfg(5'd0);
    row_chk(mbag_pkg::OP_ADD,    32'd9,    mbag_pkg::ST_FULL,      0, 0, 1, 1);
    row_chk(mbag_pkg::OP_COUNT,  32'd9,    mbag_pkg::ST_NOT_FOUND, 0, 0, 1, 1);
    // limit above the depth saturates
    row_cfg(5'd31);
    row_chk(mbag_pkg::OP_ADD,    32'h5555_5555, mbag_pkg::ST_OK,   0, 1, 0, 0);
    row_op(mbag_pkg::OP_ADD,     32'hAAAA_AAAA);
    row_op(mbag_pkg::OP_ADD,     32'h5555_5555);
    // limit dropped below what is held: nothing lost, adds refused
    row_cfg(5'd2);
    row_chk(mbag_pkg::OP_ADD,    32'd1,    mbag_pkg::ST_FULL,      0, 3, 1, 0);
    row_op(mbag_pkg::OP_COUNT,   32'h5555_5555);
    row_op(mbag_pkg::OP_REMOVE,  32'h5555_5555);
    row_op(mbag_pkg::OP_REMOVE,  32'hAAAA_AAAA);
    row_chk(mbag_pkg::OP_CLEAR,  32'd0,    mbag_pkg::ST_OK,        0, 0, 0, 1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        in_valid <= 1'b0;
        write_limit(directed_rows[i].limit);
      end else begin
        drive_op(directed_rows[i].op, directed_rows[i].val, directed_rows[i].has_want,
                 directed_rows[i].want);
      end
    end
    in_valid <= 1'b0;

    // Random phases: each picks a limit, a value pool and an operation mix
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      lim = (ph < 9) ? limit_plan[ph] : mbag_pkg::LIMIT_W'($urandom_range(0, 31));
      write_limit(lim);
      foreach (pool[k]) pool[k] = $urandom();
      if (ph == 0) begin
        pool[0] = 32'd0;
        pool[1] = ALL_ONES;
      end
      if (ph == 4) holdoff_req = 1;
      case (ph % 3)
        0: begin
          add_pct = 60;
          rem_pct = 75;
        end
        1: begin
          add_pct = 35;
          rem_pct = 65;
        end
        default: begin
          add_pct = 15;
          rem_pct = 65;
        end
      endcase
      left = PHASE_BEATS;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        if (burst > left) burst = left;
        repeat (burst) begin
          r = $urandom_range(0, 99);
          if (r < add_pct) op = mbag_pkg::OP_ADD;
          else if (r < rem_pct) op = mbag_pkg::OP_REMOVE;
          else if (r < 97) op = mbag_pkg::OP_COUNT;
          else op = mbag_pkg::OP_CLEAR;
          r = $urandom_range(0, 99);
          if (op != mbag_pkg::OP_ADD && bag_held > 0 && r < 50)
            v = bag_store[$urandom_range(0, bag_held - 1)];
          else if (r < 80)
            v = pool[$urandom_range(0, 3)];
          else
            v = $urandom();
          drive_op(op, v, 0, '0);
        end
        left -= burst;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if ($urandom_range(0, 15) == 0) gap = 25;
        if (left > 0 && gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
    end

    // Let the last results come out, then watch for strays
    wait_drained();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("results never delivered", 0, pending_results.size());

    $display("Ran %0d operations: %0d add, %0d remove, %0d count, %0d clear, over %0d limits",
             n_add + n_remove + n_count + n_clear, n_add, n_remove, n_count, n_clear, n_limits);
    $display("Adds refused as full: %0d, lookups that missed: %0d", n_rejected, n_missed);
    if (errs == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/mbag_pkg.sv
rtl/mbag_store.sv
rtl/mbag_ctrl.sv
rtl/multiset_bag_table.sv
tb/sv/tb_multiset_bag_table.sv
